FILE: hw/rtl/sexp_pkg.sv
// Shared constants, codes, byte classes and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none
package sexp_pkg;

  localparam int TOKEN_MAX_DEF = 32;

  localparam logic [2:0] KIND_SYMBOL = 3'd0;
  localparam logic [2:0] KIND_VALUE  = 3'd1;
  localparam logic [2:0] KIND_TRUE   = 3'd2;
  localparam logic [2:0] KIND_FALSE  = 3'd3;
  localparam logic [2:0] KIND_PUNCT  = 3'd4;
  localparam logic [2:0] KIND_END    = 3'd5;
  localparam logic [2:0] KIND_ERROR  = 3'd6;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_UNTERM   = 2'd1;
  localparam logic [1:0] ERR_TOO_LONG = 2'd2;
  localparam logic [1:0] ERR_BAD_CHAR = 2'd3;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_TICK   = 8'h27;

  typedef struct packed {
    logic       load;
    logic       store;
    logic       len_clear;
    logic       flush_start;
    logic       flush_run;
    logic       flush_step;
    logic       emit;
    logic       emit_flush;
    logic [2:0] emit_kind;
    logic       emit_ch_byte;
    logic       emit_empty;
    logic [1:0] emit_err;
    logic       emit_last;
  } sexp_cmd_t;

  typedef struct packed {
    logic eoi;
    logic is_blank;
    logic is_semi;
    logic is_punct;
    logic is_quote;
    logic is_nl;
    logic is_printable;
    logic is_visible;
    logic is_close;
    logic len_zero;
    logic len_full;
    logic flush_done;
    logic out_free;
  } sexp_status_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  function automatic logic is_punct(input logic [7:0] b);
    return (b == CH_LPAREN) || (b == CH_RPAREN) || (b == CH_LBRACK) ||
           (b == CH_RBRACK) || (b == CH_TICK);
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/sexp_ctrl.sv
// Tokenizer controller: lexer mode and beat sequencing state machine.
`timescale 1ns / 1ps
`default_nettype none
module sexp_ctrl import sexp_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire sexp_status_t status,
  output sexp_cmd_t         cmd
);

  typedef enum logic [1:0] {S_WAIT, S_DECODE, S_FLUSH} state_t;
  typedef enum logic [2:0] {M_IDLE, M_COMMENT, M_STRING, M_RUN, M_ERRWAIT} mode_t;

  state_t state, state_next;
  mode_t  mode, mode_next;
  logic   redecode, redecode_next;
  logic   flush_last, flush_last_next;
  logic   idle_emits;

  assign in_ready = (state == S_WAIT);
  assign idle_emits = status.is_punct ||
                      (!status.is_printable && !status.is_blank);

  always_comb begin
    state_next      = state;
    mode_next       = mode;
    redecode_next   = redecode;
    flush_last_next = flush_last;
    cmd             = '0;
    unique case (state)
      S_WAIT: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status.out_free) begin
          if (status.eoi) begin
            unique case (mode)
              M_RUN: begin
                mode_next = M_IDLE;
                if (!status.len_zero) begin
                  cmd.flush_start = 1'b1;
                  cmd.flush_run   = 1'b1;
                  redecode_next   = 1'b1;
                  flush_last_next = 1'b0;
                  state_next      = S_FLUSH;
                end
              end
              M_STRING: begin
                cmd.emit      = 1'b1;
                cmd.emit_kind = KIND_ERROR;
                cmd.emit_err  = ERR_UNTERM;
                mode_next     = M_IDLE;
              end
              default: begin
                cmd.emit      = 1'b1;
                cmd.emit_kind = KIND_END;
                cmd.emit_last = 1'b1;
                cmd.len_clear = 1'b1;
                mode_next     = M_IDLE;
                state_next    = S_WAIT;
              end
            endcase
          end else begin
            state_next = S_WAIT;
            unique case (mode)
              M_COMMENT: begin
                if (status.is_nl) mode_next = M_IDLE;
              end
              M_STRING, M_RUN: begin
                if (mode == M_STRING && status.is_quote) begin
                  if (status.len_zero) begin
                    cmd.emit       = 1'b1;
                    cmd.emit_kind  = KIND_VALUE;
                    cmd.emit_empty = 1'b1;
                    cmd.emit_last  = 1'b1;
                    mode_next      = M_IDLE;
                  end else begin
                    cmd.flush_start = 1'b1;
                    redecode_next   = 1'b0;
                    flush_last_next = 1'b1;
                    state_next      = S_FLUSH;
                  end
                end else if (mode == M_STRING ||
                             (status.is_visible && !status.is_close)) begin
                  if (status.len_full) begin
                    cmd.emit         = 1'b1;
                    cmd.emit_kind    = KIND_ERROR;
                    cmd.emit_ch_byte = 1'b1;
                    cmd.emit_err     = ERR_TOO_LONG;
                    cmd.emit_last    = 1'b1;
                    cmd.len_clear    = 1'b1;
                    mode_next        = M_ERRWAIT;
                  end else begin
                    cmd.store = 1'b1;
                  end
                end else begin
                  mode_next = M_IDLE;
                  if (status.len_zero) begin
                    state_next = S_DECODE;
                  end else begin
                    cmd.flush_start = 1'b1;
                    cmd.flush_run   = 1'b1;
                    redecode_next   = 1'b1;
                    flush_last_next = !idle_emits;
                    state_next      = S_FLUSH;
                  end
                end
              end
              M_ERRWAIT: begin
              end
              default: begin
                mode_next = M_IDLE;
                priority if (status.is_blank) begin
                end else if (status.is_semi) begin
                  mode_next = M_COMMENT;
                end else if (status.is_punct) begin
                  cmd.emit         = 1'b1;
                  cmd.emit_kind    = KIND_PUNCT;
                  cmd.emit_ch_byte = 1'b1;
                  cmd.emit_last    = 1'b1;
                end else if (status.is_quote) begin
                  cmd.len_clear = 1'b1;
                  mode_next     = M_STRING;
                end else if (!status.is_printable) begin
                  cmd.emit         = 1'b1;
                  cmd.emit_kind    = KIND_ERROR;
                  cmd.emit_ch_byte = 1'b1;
                  cmd.emit_err     = ERR_BAD_CHAR;
                  cmd.emit_last    = 1'b1;
                  cmd.len_clear    = 1'b1;
                  mode_next        = M_ERRWAIT;
                end else begin
                  cmd.len_clear = 1'b1;
                  cmd.store     = 1'b1;
                  mode_next     = M_RUN;
                end
              end
            endcase
          end
        end
      end
      S_FLUSH: begin
        if (status.out_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_flush = 1'b1;
          cmd.emit_last  = flush_last;
          cmd.flush_step = 1'b1;
          if (status.flush_done) begin
            cmd.len_clear = 1'b1;
            mode_next     = M_IDLE;
            state_next    = redecode ? S_DECODE : S_WAIT;
          end
        end
      end
      default: state_next = S_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_WAIT;
      mode       <= M_IDLE;
      redecode   <= 1'b0;
      flush_last <= 1'b0;
    end else begin
      state      <= state_next;
      mode       <= mode_next;
      redecode   <= redecode_next;
      flush_last <= flush_last_next;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sexp_dp.sv
// Tokenizer datapath: input byte, token buffer, classifier and output register.
`timescale 1ns / 1ps
`default_nettype none
module sexp_dp import sexp_pkg::*; #(
  parameter int TOKEN_MAX = TOKEN_MAX_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_eoi,
  input  wire sexp_cmd_t  cmd,
  output sexp_status_t    status,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_kind,
  output logic [7:0]      out_ch,
  output logic            out_empty,
  output logic            out_end,
  output logic [1:0]      out_err,
  output logic            out_last
);

  localparam int LW = $clog2(TOKEN_MAX + 1);
  localparam int AW = $clog2(TOKEN_MAX);

  logic [7:0]    mem [TOKEN_MAX];
  logic [7:0]    cur_byte;
  logic          cur_eoi;
  logic [LW-1:0] len, len_next;
  logic [LW-1:0] flush_idx, flush_idx_next;
  logic [AW-1:0] wr_addr;
  logic [7:0]    rd_data;
  logic [7:0]    c0, c1;
  logic          flush_run;
  logic [2:0]    run_kind;
  logic          run_lower;
  logic [2:0]    fl_kind;
  logic [7:0]    fl_ch;
  logic          flush_done;

  assign wr_addr = cmd.len_clear ? '0 : len[AW-1:0];
  assign flush_done = ((flush_idx + LW'(1)) == len);

  always_comb begin
    len_next = len;
    if (cmd.store) len_next = cmd.len_clear ? LW'(1) : len + LW'(1);
    else if (cmd.len_clear) len_next = '0;
    flush_idx_next = flush_idx;
    if (cmd.flush_start) flush_idx_next = '0;
    else if (cmd.flush_step) flush_idx_next = flush_idx + LW'(1);
  end

  always_comb begin
    run_kind  = KIND_SYMBOL;
    run_lower = 1'b1;
    priority if (is_digit(c0) || ((c0 == CH_PLUS || c0 == CH_MINUS) &&
                                  (len >= LW'(2)) && is_digit(c1))) begin
      run_kind  = KIND_VALUE;
      run_lower = 1'b0;
    end else if (c0 == CH_HASH && len == LW'(2) && (c1 == 8'h74 || c1 == 8'h54)) begin
      run_kind  = KIND_TRUE;
      run_lower = 1'b0;
    end else if (c0 == CH_HASH && len == LW'(2) && (c1 == 8'h66 || c1 == 8'h46)) begin
      run_kind  = KIND_FALSE;
      run_lower = 1'b0;
    end else begin
    end
    fl_kind = flush_run ? run_kind : KIND_VALUE;
    fl_ch   = rd_data;
    if (flush_run && run_lower && rd_data >= 8'h41 && rd_data <= 8'h5A) begin
      fl_ch = rd_data + 8'd32;
    end
  end

  always_comb begin
    status.eoi          = cur_eoi;
    status.is_blank     = is_blank(cur_byte);
    status.is_semi      = (cur_byte == CH_SEMI);
    status.is_punct     = is_punct(cur_byte);
    status.is_quote     = (cur_byte == CH_QUOTE);
    status.is_nl        = (cur_byte == CH_NL);
    status.is_printable = (cur_byte >= 8'h20) && (cur_byte <= 8'h7E);
    status.is_visible   = (cur_byte >= 8'h21) && (cur_byte <= 8'h7E);
    status.is_close     = (cur_byte == CH_RPAREN) || (cur_byte == CH_RBRACK);
    status.len_zero     = (len == '0);
    status.len_full     = (len >= LW'(TOKEN_MAX));
    status.flush_done   = flush_done;
    status.out_free     = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_byte <= in_byte;
      cur_eoi  <= in_eoi;
    end
    if (cmd.store) begin
      mem[wr_addr] <= cur_byte;
      if (wr_addr == AW'(0)) c0 <= cur_byte;
      if (wr_addr == AW'(1)) c1 <= cur_byte;
    end
    if (cmd.flush_start) flush_run <= cmd.flush_run;
    rd_data <= mem[flush_idx_next[AW-1:0]];
    if (cmd.emit) begin
      if (cmd.emit_flush) begin
        out_kind  <= fl_kind;
        out_ch    <= fl_ch;
        out_empty <= 1'b0;
        out_end   <= flush_done;
        out_err   <= ERR_NONE;
        out_last  <= cmd.emit_last && flush_done;
      end else begin
        out_kind  <= cmd.emit_kind;
        out_ch    <= cmd.emit_ch_byte ? cur_byte : 8'h00;
        out_empty <= cmd.emit_empty;
        out_end   <= 1'b1;
        out_err   <= cmd.emit_err;
        out_last  <= cmd.emit_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      flush_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      len       <= len_next;
      flush_idx <= flush_idx_next;
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/s_expression_tokenizer.sv
// Top level of the S-expression tokenizer.
// Input stream: one source byte per beat in s_tdata[7:0]; s_tlast marks end
// of text (the byte is then ignored). Output stream: one token character or
// single token per beat; m_tuser carries the kind, m_tlast marks the final
// beat caused by one input beat.
// Timing: an input beat is accepted into the byte register and decoded in the
// S_DECODE state once the output register is free; a single result lands in
// the output register at the end of the decode cycle. End of text inside a
// string gives an error beat and then an end beat. A buffered token streams
// out at one character per cycle from the token buffer memory while the output
// is not stalled; when a run ends, the byte or end of text that closed it is
// decoded again after the flush. s_tready is high only while the controller
// waits for the next byte.
// Tokens hold up to TOKEN_MAX characters.
// Reset: lexer returns to idle with an empty buffer and no beat pending.
// Stall: while m_tready is low the output register holds its beat and the
// controller waits; s_tready drops until the byte in work is done.
`timescale 1ns / 1ps
`default_nettype none
module s_expression_tokenizer import sexp_pkg::*; #(
  parameter int TOKEN_MAX = TOKEN_MAX_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // end_of_input
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] ch, [8] token_empty, [9] token_end,
                                      // [11:10] error_code, [15:12] zero
  output logic [2:0]       m_tuser,   // [2:0] kind
  output logic             m_tlast    // last
);

  sexp_cmd_t    cmd;
  sexp_status_t status;
  logic [7:0]   out_ch;
  logic         out_empty;
  logic         out_end;
  logic [1:0]   out_err;

  sexp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sexp_dp #(
    .TOKEN_MAX (TOKEN_MAX)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (s_tdata),
    .in_eoi    (s_tlast),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (m_tuser),
    .out_ch    (out_ch),
    .out_empty (out_empty),
    .out_end   (out_end),
    .out_err   (out_err),
    .out_last  (m_tlast)
  );

  assign m_tdata = {4'b0000, out_err, out_end, out_empty, out_ch};

endmodule
`default_nettype wire
